@@ sv/sequence_store_with_indexed_delete_macros.svh @@
// Assertion macros used by the sequence store controller.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef SEQUENCE_STORE_WITH_INDEXED_DELETE_MACROS_SVH
`define SEQUENCE_STORE_WITH_INDEXED_DELETE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequence store check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence store check failed");

`endif

@@ sv/ssd_pkg.sv @@
package ssd_pkg;

    // Default number of cells in the chain.
    localparam int DEPTH_DEFAULT = 32;

    // Widest cell select that the supported depth range needs.
    localparam int SEL_W = 6;

    // Operation codes of an input transfer.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE_AT  = 3'd4,
        OP_DUMP       = 3'd5
    } op_t;

    // Status codes of a result transfer.
    typedef enum logic [2:0] {
        ST_DONE  = 3'd0,
        ST_EMPTY = 3'd1,
        ST_RANGE = 3'd2,
        ST_FULL  = 3'd3,
        ST_ELEM  = 3'd4
    } status_t;

    // What every cell does in a given cycle.
    typedef enum logic [2:0] {
        CM_HOLD,
        CM_PUSH_FRONT,
        CM_APPEND,
        CM_REMOVE,
        CM_ROTATE
    } cell_mode_t;

    // Control broadcast from the sequencer to the row of cells.
    typedef struct packed {
        cell_mode_t         mode;
        logic [SEL_W-1:0]   sel;
    } cell_ctrl_t;

    // Sequencer states.
    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

endpackage

@@ sv/ssd_cell.sv @@
module ssd_cell #(
    parameter int POS = 0
) (
    input  logic                clk,
    input  ssd_pkg::cell_ctrl_t ctrl,
    input  logic [31:0]         value,
    input  logic [31:0]         left_data,
    input  logic [31:0]         right_data,
    input  logic [31:0]         head_data,
    output logic [31:0]         data
);
    import ssd_pkg::*;

    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic        at_sel;
    logic        above_sel;
    logic        below_sel;

    // Compare this cell's place with the broadcast select.
    assign at_sel    = (SEL_W'(POS) == ctrl.sel);
    assign above_sel = (SEL_W'(POS) > ctrl.sel);
    assign below_sel = (SEL_W'(POS) < ctrl.sel);

    // Choose the next content from the neighbours, the new value or the head.
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.mode)
            CM_PUSH_FRONT: data_next = (POS == 0) ? value : left_data;
            CM_APPEND:     data_next = at_sel ? value : data_reg;
            CM_REMOVE:     data_next = (at_sel || above_sel) ? right_data : data_reg;
            CM_ROTATE:
            begin
                if (at_sel)
                    data_next = head_data;
                else if (below_sel)
                    data_next = right_data;
            end
            default:       data_next = data_reg;
        endcase
    end

    // Payload register; it has no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ sv/ssd_ctrl.sv @@
`include "sequence_store_with_indexed_delete_macros.svh"

module ssd_ctrl #(
    parameter int DEPTH = ssd_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          operation,
    input  logic [4:0]          index,
    input  logic [31:0]         head_data,
    output logic                busy,
    output ssd_pkg::cell_ctrl_t ctrl,
    output logic                result_valid,
    output logic [2:0]          status,
    output logic [31:0]         element,
    output logic [4:0]          position,
    output logic [5:0]          count,
    output logic                last
);
    import ssd_pkg::*;

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int IDXW = $clog2(DEPTH);
    localparam int CMPW = (CNTW > 5) ? CNTW : 5;

    state_t            state_reg,  state_next;
    logic [CNTW-1:0]   count_reg,  count_next;
    logic [IDXW-1:0]   pos_reg,    pos_next;
    logic              valid_reg,  valid_next;
    logic [2:0]        status_reg, status_next;
    logic [31:0]       element_reg, element_next;
    logic [4:0]        position_reg, position_next;
    logic [5:0]        count_out_reg, count_out_next;
    logic              last_reg,   last_next;

    logic              full;
    logic              empty;
    logic              dump_end;
    logic [CNTW-1:0]   count_dec;

    assign full      = (count_reg == CNTW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - CNTW'(1);
    assign dump_end  = (CNTW'(pos_reg) == count_dec);

    // Sequencer: a mutation is applied straight from idle; a dump yields one element per cycle.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        valid_next     = 1'b0;
        status_next    = status_reg;
        element_next   = element_reg;
        position_next  = position_reg;
        count_out_next = count_out_reg;
        last_next      = last_reg;
        ctrl.mode      = CM_HOLD;
        ctrl.sel       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    valid_next    = 1'b1;
                    status_next   = ST_DONE;
                    element_next  = '0;
                    position_next = '0;
                    last_next     = 1'b1;
                    case (operation)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else
                            begin
                                ctrl.mode  = CM_PUSH_FRONT;
                                count_next = count_reg + CNTW'(1);
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else
                            begin
                                ctrl.mode  = CM_APPEND;
                                ctrl.sel   = SEL_W'(count_reg);
                                count_next = count_reg + CNTW'(1);
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                ctrl.mode  = CM_REMOVE;
                                count_next = count_dec;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else
                                count_next = count_dec;
                        end
                        OP_REMOVE_AT:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else if (CMPW'(index) >= CMPW'(count_reg))
                                status_next = ST_RANGE;
                            else
                            begin
                                ctrl.mode  = CM_REMOVE;
                                ctrl.sel   = SEL_W'(index);
                                count_next = count_dec;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                // Elements follow one per cycle from the dump state.
                                valid_next = 1'b0;
                                pos_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                            valid_next = 1'b0;
                    endcase
                    count_out_next = 6'(count_next);
                end
            end
            S_DUMP:
            begin
                // Rotate the chain left so that every element passes the head once.
                ctrl.mode      = CM_ROTATE;
                ctrl.sel       = SEL_W'(count_dec);
                valid_next     = 1'b1;
                status_next    = ST_ELEM;
                element_next   = head_data;
                position_next  = 5'(pos_reg);
                count_out_next = 6'(count_reg);
                last_next      = dump_end;
                pos_next       = pos_reg + IDXW'(1);
                if (dump_end)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        element_reg   <= element_next;
        position_reg  <= position_next;
        count_out_reg <= count_out_next;
        last_reg      <= last_next;
    end

    assign busy         = (state_reg == S_DUMP);
    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign element      = element_reg;
    assign position     = position_reg;
    assign count        = count_out_reg;
    assign last         = last_reg;

    // The occupancy never passes the number of cells.
    `SSD_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNTW'(DEPTH))
    // A dump in progress always has something to show.
    `SSD_ASSERT_SAME(a_dump_nonempty, state_reg == S_DUMP, count_reg != '0)
    // The final element of a dump releases the block in the next cycle.
    `SSD_ASSERT_NEXT(a_dump_ends, (state_reg == S_DUMP) && dump_end,
        (state_reg == S_IDLE) && valid_reg && last_reg)
    // The occupancy does not change during a dump.
    `SSD_ASSERT_NEXT(a_dump_count, state_reg == S_DUMP, $stable(count_reg))

endmodule

@@ sv/sequence_store_with_indexed_delete.sv @@
// Channel   Direction  Handshake                      Payload
// command   in         start high while busy low      operation, value, index
// result    out        result_valid, one cycle each   status, element, position, count, last
//
// A push, a pop or a remove at an index takes one cycle; its single result
// appears in the cycle after the transfer and the next command may be taken then.
// A dump keeps busy high while the chain of cells
// rotates once; the elements appear one per cycle, front first.
// Reset (rst_n low, asynchronous) empties the store; cell contents are not cleared.
// The receiver cannot hold results off; every result stands for exactly one cycle.
module sequence_store_with_indexed_delete #(
    parameter int DEPTH = ssd_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic signed [31:0] value,
    input  logic [4:0]  index,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic signed [31:0] element,
    output logic [4:0]  position,
    output logic [5:0]  count,
    output logic        last
);
    import ssd_pkg::*;

    cell_ctrl_t  ctrl;
    logic [31:0] cell_data [DEPTH];
    logic [31:0] elem_bits;

    // Sequencer with occupancy and result registers.
    ssd_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .operation    (operation),
        .index        (index),
        .head_data    (cell_data[0]),
        .busy         (busy),
        .ctrl         (ctrl),
        .result_valid (result_valid),
        .status       (status),
        .element      (elem_bits),
        .position     (position),
        .count        (count),
        .last         (last)
    );

    assign element = signed'(elem_bits);

    // Row of storage cells, each linked to the neighbours that it has.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ssd_cell #(
            .POS(i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .value      (value),
            .left_data  ((i == 0) ? value : cell_data[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

endmodule

@@ tb/sequence_store_checker.sv @@
`timescale 1ns / 1ps

// Watches the command and result channels of the sequence store, keeps its own
// copy of the stored sequence and compares every result transfer against the
// oldest result still due.
module sequence_store_checker #(
    parameter int DEPTH = ssd_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic [4:0]         index,
    input  logic               result_valid,
    input  logic [2:0]         status,
    input  logic signed [31:0] element,
    input  logic [4:0]         position,
    input  logic [5:0]         count,
    input  logic               last,
    output int                 failures,
    output int                 outstanding,
    output int                 compared
);

    import ssd_pkg::*;

    // One result transfer as the store should present it.
    typedef struct {
        status_t            status;
        logic signed [31:0] element;
        logic [4:0]         position;
        logic [5:0]         count;
        logic               last;
    } store_result_t;

    store_result_t      due_results[$];
    logic signed [31:0] shadow_seq[$];
    int                 error_total = 0;
    int                 checked_total = 0;

    // Queue one result, with the count taken from the sequence as it now stands.
    function automatic void add_due(input status_t st, input logic signed [31:0] el,
                                    input logic [4:0] pos, input logic fin);
        store_result_t r;
        r.status   = st;
        r.element  = el;
        r.position = pos;
        r.count    = 6'(shadow_seq.size());
        r.last     = fin;
        due_results.push_back(r);
    endfunction

    // Apply one command to the shadow sequence and queue the results it causes.
    function automatic void apply_command(input logic [2:0] op,
                                          input logic signed [31:0] val,
                                          input logic [4:0] idx);
        status_t outcome;
        int      fill;
        outcome = ST_DONE;
        fill = shadow_seq.size();
        case (op)
            OP_PUSH_FRONT:
                if (fill >= DEPTH)
                    outcome = ST_FULL;
                else
                    shadow_seq.push_front(val);
            OP_PUSH_BACK:
                if (fill >= DEPTH)
                    outcome = ST_FULL;
                else
                    shadow_seq.push_back(val);
            OP_POP_FRONT:
                if (fill == 0)
                    outcome = ST_EMPTY;
                else
                    void'(shadow_seq.pop_front());
            OP_POP_BACK:
                if (fill == 0)
                    outcome = ST_EMPTY;
                else
                    void'(shadow_seq.pop_back());
            OP_REMOVE_AT:
                // An empty store is reported before the index is looked at.
                if (fill == 0)
                    outcome = ST_EMPTY;
                else if (idx >= fill)
                    outcome = ST_RANGE;
                else
                    shadow_seq.delete(idx);
            OP_DUMP:
            begin
                if (fill == 0)
                    add_due(ST_EMPTY, '0, '0, 1'b1);
                for (int j = 0; j < fill; j++)
                    add_due(ST_ELEM, shadow_seq[j], 5'(j), (j == fill - 1));
                return;
            end
            // Reserved operation codes are dropped without a result.
            default:
                return;
        endcase
        add_due(outcome, '0, '0, 1'b1);
    endfunction

    // Compare the result transfer on the ports with the oldest one due.
    function automatic void check_result();
        store_result_t want;
        if (due_results.size() == 0)
        begin
            $display("%0t: unexpected result: status %0d element %0d count %0d",
                     $time, status, element, count);
            error_total++;
            return;
        end
        want = due_results.pop_front();
        checked_total++;
        if (status !== want.status)
        begin
            $display("%0t: status expected %0d got %0d", $time, want.status, status);
            error_total++;
        end
        if (element !== want.element)
        begin
            $display("%0t: element expected %0d got %0d", $time, want.element, element);
            error_total++;
        end
        if (position !== want.position)
        begin
            $display("%0t: position expected %0d got %0d", $time, want.position, position);
            error_total++;
        end
        if (count !== want.count)
        begin
            $display("%0t: count expected %0d got %0d", $time, want.count, count);
            error_total++;
        end
        if (last !== want.last)
        begin
            $display("%0t: last expected %0d got %0d", $time, want.last, last);
            error_total++;
        end
    endfunction

    // Results are checked before the command of the same edge is applied, since
    // a result never belongs to a command taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                check_result();
            if (start && !busy)
                apply_command(operation, value, index);
        end
        failures    <= error_total;
        outstanding <= due_results.size();
        compared    <= checked_total;
    end

endmodule

@@ tb/sequence_store_with_indexed_delete_test.sv @@
`timescale 1ns / 1ps

module sequence_store_with_indexed_delete_test;

    import ssd_pkg::*;

    localparam int STORE_DEPTH = DEPTH_DEFAULT;
    localparam int RANDOM_COMMANDS = 86;

    // Operation codes that the store leaves undefined.
    localparam logic [2:0] OP_RESERVED_A = 3'd6;
    localparam logic [2:0] OP_RESERVED_B = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         operation = OP_DUMP;
    logic signed [31:0] value = '0;
    logic [4:0]         index = '0;
    logic               busy;
    logic               result_valid;
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [4:0]         position;
    logic [5:0]         count;
    logic               last;
    int                 failures;
    int                 outstanding;
    int                 compared;

    // Stimulus bookkeeping: the length as the stimulus sees it, and what was hit.
    int fill = 0;
    int sent = 0;
    int dumps = 0;
    int refused_full = 0;
    int refused_empty = 0;
    int refused_range = 0;
    int burst_left = 0;
    bit growing = 1'b1;

    sequence_store_with_indexed_delete #(
        .DEPTH(STORE_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .value(value),
        .index(index),
        .result_valid(result_valid),
        .status(status),
        .element(element),
        .position(position),
        .count(count),
        .last(last)
    );

    sequence_store_checker #(
        .DEPTH(STORE_DEPTH)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .value(value),
        .index(index),
        .result_valid(result_valid),
        .status(status),
        .element(element),
        .position(position),
        .count(count),
        .last(last),
        .failures(failures),
        .outstanding(outstanding),
        .compared(compared)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the store hangs.
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Idle cycles before a command: mostly none or short, a few long, and now
    // and then a burst of back-to-back transfers.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            burst_left = $urandom_range(8, 20);
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    // Values lean towards the signed extremes now and then.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return '0;
            3: return 32'shffffffff;
            default: return $urandom;
        endcase
    endfunction

    // Wait out a gap, then hold start until the transfer is taken. Start is left
    // high afterwards so that the next command may follow without a gap.
    task automatic issue(input logic [2:0] op, input logic signed [31:0] val,
                         input logic [4:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        value     <= val;
        index     <= idx;
        do
            @(posedge clk);
        while (busy);
        sent++;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
                if (fill == STORE_DEPTH)
                    refused_full++;
                else
                    fill++;
            OP_POP_FRONT, OP_POP_BACK:
                if (fill == 0)
                    refused_empty++;
                else
                    fill--;
            OP_REMOVE_AT:
                if (fill == 0)
                    refused_empty++;
                else if (idx >= fill)
                    refused_range++;
                else
                    fill--;
            OP_DUMP:
                dumps++;
            default:
                ;
        endcase
    endtask

    // One random command; growing phases lean on pushes, shrinking on removals.
    task automatic random_command(output bit counted);
        int         r;
        logic [2:0] op;
        logic [4:0] idx;
        r = $urandom_range(0, 99);
        idx = 5'($urandom_range(0, 31));
        counted = 1'b1;
        if (r < 3)
        begin
            op = $urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B;
            counted = 1'b0;
        end
        else if (r < 11)
            op = OP_DUMP;
        else if (growing)
        begin
            if (r < 81)
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else if (r < 91)
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            else
                op = OP_REMOVE_AT;
        end
        else
        begin
            if (r < 26)
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else if (r < 66)
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            else
                op = OP_REMOVE_AT;
        end
        // Most removals by index hit a stored entry.
        if (op == OP_REMOVE_AT && fill > 0 && $urandom_range(0, 9) < 7)
            idx = 5'($urandom_range(0, fill - 1));
        issue(op, pick_value(), idx);
    endtask

    initial
    begin
        int n;
        bit counted;
        n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Refusals on an empty store, including a dump with nothing in it.
        issue(OP_DUMP, '0, '0);
        issue(OP_POP_FRONT, 32'sd5, 5'd3);
        issue(OP_POP_BACK, 32'sd7, 5'd31);
        issue(OP_REMOVE_AT, '0, 5'd0);
        issue(OP_REMOVE_AT, '0, 5'd31);

        // Fill from both ends with the extreme values, then dump.
        issue(OP_PUSH_FRONT, 32'sh7fffffff, 5'd31);
        issue(OP_PUSH_BACK, 32'sh80000000, 5'd0);
        issue(OP_PUSH_FRONT, '0, 5'd16);
        issue(OP_PUSH_BACK, 32'shffffffff, 5'd15);
        issue(OP_PUSH_BACK, 32'sh5a5a5a5a, 5'd10);
        issue(OP_DUMP, 32'sh12345678, 5'd21);

        // Removal at the length, far beyond it, in the middle, at the front and
        // at the back.
        issue(OP_REMOVE_AT, '0, 5'd5);
        issue(OP_REMOVE_AT, '0, 5'd31);
        issue(OP_REMOVE_AT, '0, 5'd2);
        issue(OP_REMOVE_AT, '0, 5'd0);
        issue(OP_REMOVE_AT, '0, 5'd2);

        // Reserved codes must leave no result and no change.
        issue(OP_RESERVED_A, 32'sh0badf00d, 5'd1);
        issue(OP_RESERVED_B, 32'shdeadbeef, 5'd30);
        issue(OP_DUMP, '0, '0);

        // Drain to empty, check the empty dump, then a single-entry dump.
        issue(OP_POP_FRONT, '0, '0);
        issue(OP_POP_BACK, '0, '0);
        issue(OP_DUMP, '0, '0);
        issue(OP_PUSH_BACK, 32'sh12345678, 5'd4);
        issue(OP_DUMP, '0, '0);

        // Random phase: at least RANDOM_COMMANDS commands, and on until a push hits a full store.
        while (n < RANDOM_COMMANDS || refused_full == 0)
        begin
            if (growing && fill == STORE_DEPTH && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (!growing && fill == 0 && $urandom_range(0, 2) == 0)
                growing = 1'b1;
            random_command(counted);
            if (counted)
                n++;
        end
        start <= 1'b0;

        // Let the last results drain, then allow for a full dump more.
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (STORE_DEPTH + 8) @(posedge clk);

        $display("Sent %0d commands, %0d of them dumps; %0d results compared.",
                 sent, dumps, compared);
        $display("Refused: %0d pushes when full, %0d on empty, %0d index out of range.",
                 refused_full, refused_empty, refused_range);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
